### rtl/core/chs_pkg.sv
// shared types and constants for the chained hash set engine
package chs_pkg;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  localparam int OP_W  = 2;
  localparam int KEY_W = 48;
  // byte sum of six bytes stays below 2048
  localparam int SUM_W = 11;
  // fixed-point shift for the reciprocal used in the bucket modulo
  localparam int MOD_K = 22;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic quot_en;
    logic rem_en;
    logic rd_en;
    logic upd_en;
    logic clr_en;
  } chs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
  } chs_sts_t;

endpackage

### rtl/core/chs_ctrl.sv
// controller state machine for the chained hash set engine
module chs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output chs_pkg::chs_cmd_t cmd,
  input  chs_pkg::chs_sts_t sts
);
  import chs_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_QUOT  = 3'd2;
  localparam logic [2:0] S_REM   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_QUOT;
        end
      end
      S_QUOT: begin
        cmd.quot_en = 1'b1;
        state_nxt   = S_REM;
      end
      S_REM: begin
        cmd.rem_en = 1'b1;
        state_nxt  = S_READ;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // hold until the result register can take the transaction
        if (slot_free) begin
          cmd.upd_en    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_QUOT))
    else $error("accepted transaction did not start the hash");

  a_update_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_en |=> out_valid_r)
    else $error("update did not produce a result");

endmodule

### rtl/core/chs_dp.sv
// datapath: key hash, bucket modulo, slot memories and parallel compare
module chs_dp #(
  parameter int BUCKETS          = 4,
  parameter int KEY_BYTES        = 6,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [chs_pkg::OP_W-1:0]  in_operation,
  input  logic [chs_pkg::KEY_W-1:0] in_key,
  input  chs_pkg::chs_cmd_t         cmd,
  output chs_pkg::chs_sts_t         sts,
  output logic                      out_found,
  output logic                      out_bucket_full
);
  import chs_pkg::*;

  localparam int BKT_W      = $clog2(BUCKETS);
  localparam int SLOTS      = SLOTS_PER_BUCKET;
  localparam int USED_BYTES = (KEY_BYTES < (KEY_W / 8)) ? KEY_BYTES : (KEY_W / 8);
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((65'd1 << (8 * USED_BYTES)) - 65'd1);
  localparam logic [MOD_K:0]   RECIP = (MOD_K + 1)'((2 ** MOD_K + BUCKETS - 1) / BUCKETS);
  localparam logic [SUM_W-1:0] BKT_CNT = SUM_W'(BUCKETS);
  localparam int PROD_W = SUM_W + MOD_K + 1;

  // slot memories, one row per bucket
  logic [SLOTS-1:0][KEY_W-1:0] key_mem [BUCKETS];
  logic [SLOTS-1:0]            vld_mem [BUCKETS];

  logic [OP_W-1:0]             op_r;
  logic [KEY_W-1:0]            key_r;
  logic [KEY_W-1:0]            key_in_m;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [SUM_W-1:0]            quot_r;
  logic [PROD_W-1:0]           prod;
  logic [SUM_W-1:0]            qb, rem_raw, rem_fix;
  logic [BKT_W-1:0]            bucket_r;
  logic [BKT_W-1:0]            clr_cnt_r;
  logic [SLOTS-1:0][KEY_W-1:0] rd_keys_r;
  logic [SLOTS-1:0]            rd_vld_r;
  logic [SLOTS-1:0]            hit_vec, hit_oh, free_oh;
  logic [SLOTS-1:0][KEY_W-1:0] new_keys;
  logic [SLOTS-1:0]            new_vld;
  logic                        found, do_insert, do_delete, full;
  logic                        found_r, full_r;

  assign key_in_m = in_key & KEY_MASK;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < KEY_W / 8; i++) begin
      sum_nxt = sum_nxt + SUM_W'(key_in_m[8*i +: 8]);
    end
  end

  // modulo by reciprocal: quotient, then remainder with one correction step
  assign prod    = PROD_W'(sum_r) * PROD_W'(RECIP);
  assign qb      = SUM_W'(quot_r * BKT_CNT);
  assign rem_raw = sum_r - qb;
  assign rem_fix = (rem_raw >= BKT_CNT) ? (rem_raw - BKT_CNT) : rem_raw;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_operation;
      key_r <= key_in_m;
      sum_r <= sum_nxt;
    end
    if (cmd.quot_en) begin
      quot_r <= prod[MOD_K +: SUM_W];
    end
    if (cmd.rem_en) begin
      bucket_r <= BKT_W'(rem_fix);
    end
    if (cmd.rd_en) begin
      rd_keys_r <= key_mem[bucket_r];
      rd_vld_r  <= vld_mem[bucket_r];
    end
  end

  // compare all slots of the row at once
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      hit_vec[s] = rd_vld_r[s] && (rd_keys_r[s] == key_r);
    end
  end

  assign hit_oh  = hit_vec & (~hit_vec + SLOTS'(1));
  assign free_oh = ~rd_vld_r & (rd_vld_r + SLOTS'(1));
  assign found   = |hit_vec;

  always_comb begin
    do_insert = 1'b0;
    do_delete = 1'b0;
    case (op_r)
      OP_INSERT: do_insert = !found && !(&rd_vld_r);
      OP_DELETE: do_delete = found;
      default:   ;
    endcase
  end

  assign full = (op_r == OP_INSERT) && !found && (&rd_vld_r);

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      new_keys[s] = free_oh[s] ? key_r : rd_keys_r[s];
    end
    new_vld = rd_vld_r;
    if (do_insert) begin
      new_vld = rd_vld_r | free_oh;
    end else if (do_delete) begin
      new_vld = rd_vld_r & ~hit_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en && do_insert) begin
      key_mem[bucket_r] <= new_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      vld_mem[clr_cnt_r] <= '0;
    end else if (cmd.upd_en) begin
      vld_mem[bucket_r] <= new_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + BKT_W'(1);
    end
  end

  assign sts.clr_last = (clr_cnt_r == BKT_W'(BUCKETS - 1));

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      found_r <= found;
      full_r  <= full;
    end
  end

  assign out_found       = found_r;
  assign out_bucket_full = full_r;

  a_bucket_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem_en |=> (SUM_W'(bucket_r) < BKT_CNT))
    else $error("bucket index out of range");

  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_en |-> $onehot0(hit_oh) && $onehot0(free_oh))
    else $error("more than one slot selected");

  a_full_only_when_row_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd_en && full) |=> (out_bucket_full && !out_found))
    else $error("bucket full flag inconsistent");

endmodule

### rtl/core/chained_hash_set_engine.sv
// top level of the chained hash set engine
// A set of short keys kept in BUCKETS buckets of SLOTS_PER_BUCKET slots each.
// Each input transaction asks for an insert, a delete or a membership test of
// one key; the bucket is the unsigned byte sum of the key modulo BUCKETS. One
// result transaction comes back per input: found tells whether the key was in
// the set before the operation, bucket_full flags an insert refused because
// its bucket had no free slot. From acceptance to its result an item goes
// through these steps: latch and hash the key, the bucket modulo (a
// reciprocal multiply, then a multiply and correction), the registered read
// of the bucket row, and the compare of all slots in parallel with the row
// write-back. The block takes one item at a time; the next item is accepted
// while a finished result still waits in the output register.
// After reset a clearing pass zeroes the slot valid bits of every bucket;
// in_ready stays low until it completes.
module chained_hash_set_engine #(
  parameter int BUCKETS          = 4,
  parameter int KEY_BYTES        = 6,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [chs_pkg::OP_W-1:0]  in_operation,
  input  logic [chs_pkg::KEY_W-1:0] in_key,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic                      out_bucket_full
);
  import chs_pkg::*;

  // command and status between controller and datapath
  chs_cmd_t cmd;
  chs_sts_t sts;

  // sequencing: clear pass, accept, hash steps, row read, update
  chs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // hashing, slot memories and result registers
  chs_dp #(
    .BUCKETS          (BUCKETS),
    .KEY_BYTES        (KEY_BYTES),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .cmd             (cmd),
    .sts             (sts),
    .out_found       (out_found),
    .out_bucket_full (out_bucket_full)
  );

endmodule

### dv/chained_hash_set_engine_tb.sv
// self-checking testbench for the chained hash set engine with a built-in set predictor
module chained_hash_set_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chs_pkg::*;

  localparam int BUCKETS          = 4;
  localparam int KEY_BYTES        = 6;
  localparam int SLOTS_PER_BUCKET = 8;
  localparam int TOTAL_SLOTS      = BUCKETS * SLOTS_PER_BUCKET;

  // code 3 has no name in the package; the block treats it as a membership test
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BYTES >= KEY_W / 8) ? {KEY_W{1'b1}} : ((48'd1 << (8 * KEY_BYTES)) - 48'd1);

  localparam int RANDOM_ITEMS  = 1650;
  localparam int POOL_PER_BKT  = 11;   // more than a bucket holds, so buckets fill up
  localparam int STALL_LIMIT   = 2000; // cycles without any transaction before giving up
  localparam int DRAIN_CYCLES  = 20;   // leave plenty of margin
  localparam int MAX_REPORTED  = 10;

  typedef struct packed {
    logic found;
    logic bucket_full;
  } outcome_t;

  // ---------------------------------------------------------------------------
  // set predictor and outcome checker
  // keeps its own copy of the slot table and a queue of predicted outcomes, in
  // the order the requests were accepted
  // ---------------------------------------------------------------------------
  class set_membership_tracker;
    logic [KEY_W-1:0] stored_key [TOTAL_SLOTS];
    logic             slot_live  [TOTAL_SLOTS];
    outcome_t         expected_outcomes [$];
    int               failures;

    function new();
      failures = 0;
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        stored_key[i] = '0;
        slot_live[i]  = 1'b0;
      end
    endfunction

    // unsigned byte sum of the used key bytes, modulo the bucket count
    function int unsigned bucket_of_key(logic [KEY_W-1:0] k);
      int unsigned sum;
      sum = 0;
      for (int b = 0; b < KEY_BYTES && b < KEY_W / 8; b++) begin
        sum += k[8*b +: 8];
      end
      return sum % BUCKETS;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] raw_key);
      logic [KEY_W-1:0] k;
      int unsigned      base;
      int               hit;
      int               free_slot;
      outcome_t         e;
      k         = raw_key & KEY_MASK;
      base      = bucket_of_key(k) * SLOTS_PER_BUCKET;
      hit       = -1;
      free_slot = -1;
      // whole bucket row compared at once: first matching live slot, lowest free slot
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
        if (slot_live[base + s]) begin
          if (hit < 0 && stored_key[base + s] == k) hit = base + s;
        end else if (free_slot < 0) begin
          free_slot = base + s;
        end
      end
      e.found       = (hit >= 0);
      e.bucket_full = 1'b0;
      case (op)
        OP_INSERT: begin
          if (hit < 0) begin
            if (free_slot >= 0) begin
              stored_key[free_slot] = k;
              slot_live[free_slot]  = 1'b1;
            end else begin
              e.bucket_full = 1'b1;
            end
          end
        end
        OP_DELETE: begin
          if (hit >= 0) slot_live[hit] = 1'b0;
        end
        default: begin
          // membership test and the spare code leave the table alone
        end
      endcase
      expected_outcomes.push_back(e);
    endfunction

    function void check_response(logic found, logic bucket_full);
      outcome_t e;
      if (expected_outcomes.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTED)
          $display("[%0t] result transaction with nothing expected: found=%0b full=%0b",
                   $realtime, found, bucket_full);
        return;
      end
      e = expected_outcomes.pop_front();
      if (found !== e.found || bucket_full !== e.bucket_full) begin
        failures++;
        if (failures <= MAX_REPORTED)
          $display("[%0t] mismatch: found exp %0b got %0b, bucket_full exp %0b got %0b",
                   $realtime, e.found, found, e.bucket_full, bucket_full);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and block under test
  // ---------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [OP_W-1:0]  in_operation;
  logic [KEY_W-1:0] in_key;
  logic             out_valid;
  logic             out_ready;
  logic             out_found;
  logic             out_bucket_full;

  set_membership_tracker tracker;
  logic [KEY_W-1:0]      key_pool [$];
  bit                    no_gaps = 1'b0;   // set during the stretch with no idling
  int                    quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  chained_hash_set_engine #(
    .BUCKETS          (BUCKETS),
    .KEY_BYTES        (KEY_BYTES),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_bucket_full (out_bucket_full)
  );

  // ---------------------------------------------------------------------------
  // monitor: both channels are sampled at the rising edge, before this edge's
  // updates land, so the handshake seen here is the one the block acted on
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_request(in_operation, in_key);
      if (out_valid && out_ready) tracker.check_response(out_found, out_bucket_full);
      // watchdog: only cycles with no transaction on either side count
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side back-pressure: ready drops at random, odds 0.36, high while no_gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 36);
    end
  end

  // ---------------------------------------------------------------------------
  // request driver
  // valid is lowered only when an idle gap is actually taken, so a valid that
  // carries straight into the next request never sees two assignments in one step
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 36) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= k;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the request side off until every outstanding result has come back
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    return KEY_W'({$urandom(), $urandom()});
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [KEY_W-1:0] k;
    logic [OP_W-1:0]  op;
    int               r;
    bit               insert_heavy;

    tracker      = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_INSERT;
    in_key       <= '0;

    // working set: POOL_PER_BKT keys per bucket, so every bucket can overflow
    for (int b = 0; b < BUCKETS; b++) begin
      for (int j = 0; j < POOL_PER_BKT; j++) begin
        k = random_key();
        while (tracker.bucket_of_key(k) != b) k[7:0] = k[7:0] + 8'd1;
        key_pool.push_back(k);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // the clearing pass after reset keeps in_ready low; the driver just waits

    // directed part
    send_request(OP_TEST,   48'h0);               // empty set, absent key
    send_request(OP_INSERT, 48'h0);               // all-zero key
    send_request(OP_INSERT, 48'h0);               // insert of a key already present
    send_request(OP_TEST,   48'h0);
    send_request(OP_INSERT, 48'hFFFF_FFFF_FFFF);  // all-ones key, largest byte sum
    send_request(OP_SPARE,  48'hFFFF_FFFF_FFFF);  // spare code acts as a test
    send_request(OP_DELETE, 48'hFFFF_FFFF_FFFF);
    send_request(OP_DELETE, 48'hFFFF_FFFF_FFFF);  // delete of an absent key
    send_request(OP_INSERT, 48'h4100_4200_0000);  // zero byte inside the key
    send_request(OP_TEST,   48'h4100_0000_0000);  // its truncation is a different key
    send_request(OP_TEST,   48'h4100_4200_0000);
    // fill bucket 1 with eight small keys, then overflow it
    for (int j = 0; j < SLOTS_PER_BUCKET; j++) send_request(OP_INSERT, 48'(1 + 4 * j));
    send_request(OP_INSERT, 48'd33);             // refused, bucket full
    send_request(OP_DELETE, 48'd5);              // frees a slot in the middle
    send_request(OP_INSERT, 48'd33);             // lands in the freed slot
    send_request(OP_TEST,   48'd5);

    // let the pipeline empty before the random traffic
    wait_until_drained();

    // random part: alternating insert-heavy and delete-heavy phases over a small
    // working set so buckets keep filling and emptying, plus some fresh keys
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_gaps      = (i >= 500 && i < 850);
      insert_heavy = ((i / 150) % 2 == 0);
      if (i == 1000) wait_until_drained();
      r = $urandom_range(0, 99);
      if (insert_heavy) begin
        op = (r < 55) ? OP_INSERT : (r < 75) ? OP_DELETE : (r < 96) ? OP_TEST : OP_SPARE;
      end else begin
        op = (r < 30) ? OP_INSERT : (r < 65) ? OP_DELETE : (r < 96) ? OP_TEST : OP_SPARE;
      end
      if ($urandom_range(0, 99) < 85) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else begin
        k = random_key();
      end
      send_request(op, k);
    end
    no_gaps = 1'b0;

    // wind down: every result back, then a further wait for stray output
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
